// ===== hw/rtl/ps2_pkg.sv =====
// Shared constants and types for the PS/2 set-2 scan code decoder.
package ps2_pkg;

    localparam logic [7:0] PFX_RELEASE = 8'hF0;
    localparam logic [7:0] PFX_EXTEND  = 8'hE0;
    localparam logic [7:0] PFX_PAUSE   = 8'hE1;
    localparam logic [7:0] PAUSE_MID   = 8'h14;
    localparam logic [7:0] PAUSE_END   = 8'h77;
    localparam logic [7:0] PAUSE_CODE  = 8'h7F;

    typedef logic [1:0] event_kind_t;
    localparam event_kind_t KIND_DOWN = 2'd0;
    localparam event_kind_t KIND_UP   = 2'd1;
    localparam event_kind_t KIND_RAW  = 2'd2;

    typedef logic [1:0] pause_stage_t;
    localparam pause_stage_t PAUSE_IDLE     = 2'd0;
    localparam pause_stage_t PAUSE_GOT_MID  = 2'd1;
    localparam pause_stage_t PAUSE_GOT_OPEN = 2'd2;

endpackage

// ===== hw/rtl/ps2_ifs.sv =====
// Valid/ready channel interfaces for scan bytes, key events and configuration.
interface ps2_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] scan_byte;

    modport source (output valid, output scan_byte, input ready);
    modport sink (input valid, input scan_byte, output ready);
endinterface

interface ps2_event_if;
    logic                valid;
    logic                ready;
    ps2_pkg::event_kind_t event_kind;
    logic [7:0]          key_code;

    modport source (output valid, output event_kind, output key_code, input ready);
    modport sink (input valid, input event_kind, input key_code, output ready);
endinterface

interface ps2_cfg_if;
    logic valid;
    logic ready;
    logic raw_mode;

    modport source (output valid, output raw_mode, input ready);
    modport sink (input valid, input raw_mode, output ready);
endinterface

// ===== hw/rtl/ps2_scancode_set2_decoder.sv =====
// Top level of the PS/2 scan code set 2 decoder.
//
// Each transfer on byte_in carries one keyboard byte and is decoded in the
// cycle it is accepted; its key event, if any, appears on event_out from the
// following cycle in the output register. One byte is taken per clock: the
// only limit is that single output register, so byte_in stalls only while a
// finished event waits on event_out. Outside raw mode, prefix bytes (F0, E0,
// E1) and repeated presses of the last key give no event. Writes on cfg set
// raw mode, where every byte passes as a raw event; write it only while idle.
module ps2_scancode_set2_decoder (
    input  logic          clk,
    input  logic          rst_n,
    ps2_byte_if.sink      byte_in,
    ps2_event_if.source   event_out,
    ps2_cfg_if.sink       cfg
);

    logic                   raw_mode_reg;
    logic                   release_pending_reg, release_pending_next;
    logic                   extend_pending_reg, extend_pending_next;
    ps2_pkg::pause_stage_t  pause_stage_reg, pause_stage_next;
    logic [7:0]             last_pressed_reg, last_pressed_next;
    logic                   out_valid_reg, out_valid_next;
    ps2_pkg::event_kind_t   kind_reg, kind_next;
    logic [7:0]             code_reg, code_next;

    logic       in_ready;
    logic       in_xfer;
    logic       emit;
    logic [7:0] b;
    logic [7:0] key;

    assign cfg.ready = 1'b1;
    assign in_ready = !out_valid_reg || event_out.ready;
    assign byte_in.ready = in_ready;
    assign in_xfer = byte_in.valid && in_ready;
    assign b = byte_in.scan_byte;

    assign event_out.valid = out_valid_reg;
    assign event_out.event_kind = kind_reg;
    assign event_out.key_code = code_reg;

    always_comb
    begin
        release_pending_next = release_pending_reg;
        extend_pending_next  = extend_pending_reg;
        pause_stage_next     = pause_stage_reg;
        last_pressed_next    = last_pressed_reg;
        emit                 = 1'b0;
        kind_next            = kind_reg;
        code_next            = code_reg;
        key                  = {b[7] | extend_pending_reg, b[6:0]};

        if (raw_mode_reg)
        begin
            emit      = 1'b1;
            kind_next = ps2_pkg::KIND_RAW;
            code_next = b;
        end
        else if (b == ps2_pkg::PFX_RELEASE)
        begin
            release_pending_next = 1'b1;
        end
        else if (b == ps2_pkg::PFX_EXTEND)
        begin
            extend_pending_next = 1'b1;
        end
        else if (b == ps2_pkg::PFX_PAUSE)
        begin
            pause_stage_next = ps2_pkg::PAUSE_GOT_OPEN;
        end
        else
        begin
            extend_pending_next = 1'b0;
            if (pause_stage_reg == ps2_pkg::PAUSE_GOT_OPEN && b == ps2_pkg::PAUSE_MID)
            begin
                pause_stage_next = ps2_pkg::PAUSE_GOT_MID;
            end
            else
            begin
                if (pause_stage_reg == ps2_pkg::PAUSE_GOT_MID && b == ps2_pkg::PAUSE_END)
                begin
                    key = ps2_pkg::PAUSE_CODE;
                end
                pause_stage_next = ps2_pkg::PAUSE_IDLE;
                if (release_pending_reg)
                begin
                    release_pending_next = 1'b0;
                    last_pressed_next    = 8'h00;
                    emit                 = 1'b1;
                    kind_next            = ps2_pkg::KIND_UP;
                    code_next            = key;
                end
                else if (key != last_pressed_reg)
                begin
                    last_pressed_next = key;
                    emit              = 1'b1;
                    kind_next         = ps2_pkg::KIND_DOWN;
                    code_next         = key;
                end
            end
        end

        if (in_xfer)
        begin
            out_valid_next = emit;
        end
        else if (event_out.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_mode_reg        <= 1'b0;
            release_pending_reg <= 1'b0;
            extend_pending_reg  <= 1'b0;
            pause_stage_reg     <= ps2_pkg::PAUSE_IDLE;
            last_pressed_reg    <= 8'h00;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                raw_mode_reg <= cfg.raw_mode;
            end
            if (in_xfer)
            begin
                release_pending_reg <= release_pending_next;
                extend_pending_reg  <= extend_pending_next;
                pause_stage_reg     <= pause_stage_next;
                last_pressed_reg    <= last_pressed_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer && emit)
        begin
            kind_reg <= kind_next;
            code_reg <= code_next;
        end
    end

    a_no_stage3: assert property (@(posedge clk) disable iff (!rst_n)
        pause_stage_reg != 2'd3)
        else $error("pause stage reached unused code");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> kind_reg != 2'd3)
        else $error("invalid event kind on output");

    a_raw_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && raw_mode_reg) |=>
            (out_valid_reg && kind_reg == ps2_pkg::KIND_RAW && code_reg == $past(b)))
        else $error("raw byte not passed through");

    a_down_remembered: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && emit && kind_next == ps2_pkg::KIND_DOWN) |=>
            (last_pressed_reg == code_reg))
        else $error("key-down not remembered");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid_reg)
        else $error("input stalled with empty output");

endmodule
